/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers. Compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

/* rtl/core/uer_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uer_pkg
// Types and constants for the ultrasonic echo ranger.
// ----------------------------------------------------------------------------
package uer_pkg;

    localparam logic [15:0] TRIG_US      = 16'd10;     // trigger high/low length
    localparam logic [10:0] TICK_Q8_NUM  = 11'd1124;   // 0.0343/2 cm per tick, Q16
    localparam logic [17:0] DIST_MAX     = 18'd131840;

    localparam logic [15:0] TIMEOUT_RST  = 16'd30000;
    localparam logic [17:0] WARN_THR_RST = 18'd2560;
    localparam logic [19:0] WARN_HOLD_RST = 20'd500000;

    // configuration register indexes
    localparam logic [1:0] CFG_TIMEOUT   = 2'd0;
    localparam logic [1:0] CFG_WARN_THR  = 2'd1;
    localparam logic [1:0] CFG_WARN_HOLD = 2'd2;

    typedef struct packed {
        logic cmd;
        logic echo_level;
    } t_in;

    typedef struct packed {
        logic        trig_level;
        logic        warning_level;
        logic        busy_res;
        logic        done_res;
        logic        timed_out;
        logic [17:0] distance_q8;
    } t_out;

endpackage

/* rtl/core/ultrasonic_echo_ranger.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// Trigger/echo ranging controller with proximity warning, one tick per item.
//
//   channel  direction  handshake              payload
//   in       sink       i_in_valid/o_in_stall  t_in  (cmd, echo_level)
//   out      source     o_out_valid/i_out_stall t_out (levels, done, distance)
//   cfg      sink       i_cfg_valid/o_cfg_ready index 2b, data 20b
//
// One item per cycle sustained while the output does not stall; an item passes the
// input register, then the single-pass state update into the result register (one 16x11 multiply).
// Synchronous active-low reset clears phase, counters, warning and valids;
// config registers reset to their defaults. An output stall holds the result
// register; the input register still takes an item when the result moves.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ultrasonic_echo_ranger
    import uer_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TRIG_HIGH,
        PH_TRIG_LOW,
        PH_WAIT_RISE,
        PH_TIME_HIGH
    } t_phase;

    logic [15:0] r_timeout;
    logic [17:0] r_warn_thr;
    logic [19:0] r_warn_hold;

    logic        r_in_valid;
    t_in         r_in;
    logic        r_out_valid;
    t_out        r_out;

    t_phase      r_phase,   n_phase;
    logic [15:0] r_elapsed, n_elapsed;
    logic [19:0] r_hold,    n_hold;
    logic        r_warn,    n_warn;
    t_out        n_out;

    logic        w_adv;
    logic [15:0] w_base;
    logic [15:0] w_inc;
    logic [26:0] w_prod;
    logic [18:0] w_scaled;
    logic [17:0] w_dist;

    assign w_adv       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !w_adv;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    // end of trigger-low already counts as the first rise wait tick
    assign w_base   = (r_phase == PH_TRIG_LOW) ? 16'd0 : r_elapsed;
    assign w_inc    = (w_base != 16'hFFFF) ? w_base + 16'd1 : w_base;
    assign w_prod   = {11'd0, r_elapsed} * {16'd0, TICK_Q8_NUM};
    assign w_scaled = w_prod[26:8];
    assign w_dist   = (w_scaled > {1'b0, DIST_MAX}) ? DIST_MAX : w_scaled[17:0];

    always_comb begin
        n_phase   = r_phase;
        n_elapsed = r_elapsed;
        n_hold    = r_hold;
        n_warn    = r_warn;
        n_out     = '0;

        if (r_warn) begin
            if (r_hold <= 20'd1) begin
                n_hold = '0;
                n_warn = 1'b0;
            end else begin
                n_hold = r_hold - 20'd1;
            end
        end

        case (r_phase)
            PH_IDLE: begin
                if (r_in.cmd) begin
                    n_phase          = PH_TRIG_HIGH;
                    n_elapsed        = 16'd1;
                    n_out.trig_level = 1'b1;
                end
            end
            PH_TRIG_HIGH: begin
                if (r_elapsed >= TRIG_US) begin
                    n_phase   = PH_TRIG_LOW;
                    n_elapsed = 16'd1;
                end else begin
                    n_elapsed        = r_elapsed + 16'd1;
                    n_out.trig_level = 1'b1;
                end
            end
            PH_TRIG_LOW, PH_WAIT_RISE: begin
                if (r_phase == PH_TRIG_LOW && r_elapsed < TRIG_US) begin
                    n_elapsed = r_elapsed + 16'd1;
                end else if (r_in.echo_level) begin
                    n_phase   = PH_TIME_HIGH;
                    n_elapsed = 16'd1;
                end else if (w_inc >= r_timeout) begin
                    n_phase         = PH_IDLE;
                    n_elapsed       = '0;
                    n_out.done_res  = 1'b1;
                    n_out.timed_out = 1'b1;
                end else begin
                    n_phase   = PH_WAIT_RISE;
                    n_elapsed = w_inc;
                end
            end
            PH_TIME_HIGH: begin
                if (!r_in.echo_level) begin
                    n_phase           = PH_IDLE;
                    n_elapsed         = '0;
                    n_out.done_res    = 1'b1;
                    n_out.distance_q8 = w_dist;
                    if (w_dist < r_warn_thr) begin
                        n_warn = 1'b1;
                        n_hold = r_warn_hold;
                    end
                end else if (w_inc >= r_timeout) begin
                    n_phase         = PH_IDLE;
                    n_elapsed       = '0;
                    n_out.done_res  = 1'b1;
                    n_out.timed_out = 1'b1;
                end else begin
                    n_elapsed = w_inc;
                end
            end
            default: begin
                n_phase   = PH_IDLE;
                n_elapsed = '0;
            end
        endcase

        n_out.warning_level = n_warn;
        n_out.busy_res      = (n_phase != PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= TIMEOUT_RST;
            r_warn_thr  <= WARN_THR_RST;
            r_warn_hold <= WARN_HOLD_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TIMEOUT:   r_timeout   <= i_cfg_data[15:0];
                CFG_WARN_THR:  r_warn_thr  <= i_cfg_data[17:0];
                CFG_WARN_HOLD: r_warn_hold <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_elapsed   <= '0;
            r_hold      <= '0;
            r_warn      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_phase     <= n_phase;
                r_elapsed   <= n_elapsed;
                r_hold      <= n_hold;
                r_warn      <= n_warn;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    `ASSERT_IMP(a_idle_clear, i_clk, i_rst_n, r_phase == PH_IDLE, r_elapsed == 16'd0)
    `ASSERT_IMP(a_warn_hold, i_clk, i_rst_n, !r_warn, r_hold == 20'd0)
    `ASSERT_IMP(a_done_idle, i_clk, i_rst_n, r_out_valid && r_out.done_res, !r_out.busy_res)
    `ASSERT_IMP(a_tmo_done, i_clk, i_rst_n, r_out_valid && r_out.timed_out, r_out.done_res && r_out.distance_q8 == 18'd0)
    `ASSERT_NXT(a_trig_busy, i_clk, i_rst_n, w_adv && n_out.trig_level, r_phase == PH_TRIG_HIGH)

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for ultrasonic_echo_ranger. Ticks go in with random
// gaps, results come out under random stalls, and a scoreboard that models
// trigger, echo timing, distance and warning hold checks every reading.
// Directed ranging runs come first, then phases of random ranging runs and
// noise under varied register settings.
// ----------------------------------------------------------------------------
module testbench;
    import uer_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TRIG_HIGH,
        PH_TRIG_LOW,
        PH_WAIT_RISE,
        PH_TIME_HIGH
    } t_phase;

    class echo_scoreboard;
        t_out        expected_readings[$];
        int unsigned errors;
        logic [15:0] timeout_us;
        logic [17:0] warn_thr;
        logic [19:0] warn_hold;
        t_phase      phase;
        int unsigned elapsed;
        logic [19:0] hold_left;
        logic        warn_on;

        function new();
            errors     = 0;
            timeout_us = TIMEOUT_RST;
            warn_thr   = WARN_THR_RST;
            warn_hold  = WARN_HOLD_RST;
            phase      = PH_IDLE;
            elapsed    = 0;
            hold_left  = '0;
            warn_on    = 1'b0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [19:0] val);
            case (idx)
                CFG_TIMEOUT:   timeout_us = val[15:0];
                CFG_WARN_THR:  warn_thr   = val[17:0];
                CFG_WARN_HOLD: warn_hold  = val;
                default: ;
            endcase
        endfunction

        // one more tick in an echo wait; ends the run on timeout
        function void count_wait(inout t_out r);
            if (elapsed < 32'hFFFF)
                elapsed++;
            if (elapsed >= timeout_us) begin
                phase       = PH_IDLE;
                elapsed     = 0;
                r.done_res  = 1'b1;
                r.timed_out = 1'b1;
            end
        endfunction

        function t_out predict_tick(t_in it);
            t_out        r;
            logic        rise_wait;
            int unsigned d;
            r         = '0;
            rise_wait = 1'b0;
            if (warn_on) begin
                if (hold_left <= 1) begin
                    hold_left = '0;
                    warn_on   = 1'b0;
                end else begin
                    hold_left = hold_left - 1'b1;
                end
            end
            case (phase)
                PH_IDLE: begin
                    if (it.cmd) begin
                        phase        = PH_TRIG_HIGH;
                        elapsed      = 1;
                        r.trig_level = 1'b1;
                    end
                end
                PH_TRIG_HIGH: begin
                    if (elapsed >= TRIG_US) begin
                        phase   = PH_TRIG_LOW;
                        elapsed = 1;
                    end else begin
                        elapsed++;
                        r.trig_level = 1'b1;
                    end
                end
                PH_TRIG_LOW: begin
                    if (elapsed < TRIG_US) begin
                        elapsed++;
                    end else begin
                        // end of low pulse is already the first rise wait tick
                        phase     = PH_WAIT_RISE;
                        elapsed   = 0;
                        rise_wait = 1'b1;
                    end
                end
                PH_WAIT_RISE: rise_wait = 1'b1;
                PH_TIME_HIGH: begin
                    if (!it.echo_level) begin
                        d = (elapsed * TICK_Q8_NUM) >> 8;
                        if (d > DIST_MAX)
                            d = DIST_MAX;
                        r.distance_q8 = d[17:0];
                        r.done_res    = 1'b1;
                        phase         = PH_IDLE;
                        elapsed       = 0;
                        if (d < warn_thr) begin
                            warn_on   = 1'b1;
                            hold_left = warn_hold;
                        end
                    end else begin
                        count_wait(r);
                    end
                end
                default: begin
                    phase   = PH_IDLE;
                    elapsed = 0;
                end
            endcase
            if (rise_wait) begin
                if (it.echo_level) begin
                    phase   = PH_TIME_HIGH;
                    elapsed = 1;
                end else begin
                    count_wait(r);
                end
            end
            r.warning_level = warn_on;
            r.busy_res      = (phase != PH_IDLE);
            return r;
        endfunction

        function void note_tick(t_in it);
            expected_readings.push_back(predict_tick(it));
        endfunction

        function void check_reading(t_out got);
            t_out want;
            if (expected_readings.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected reading: %p", got);
                return;
            end
            want = expected_readings.pop_front();
            if (got.trig_level !== want.trig_level ||
                got.warning_level !== want.warning_level ||
                got.busy_res !== want.busy_res ||
                got.done_res !== want.done_res ||
                got.timed_out !== want.timed_out ||
                got.distance_q8 !== want.distance_q8) begin
                errors++;
                if (errors <= 10)
                    $display("reading mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        o_in_stall;
    t_in         in_data = '0;
    logic        o_out_valid;
    logic        out_stall = 1'b0;
    t_out        o_out_data;
    logic        cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  cfg_index = CFG_TIMEOUT;
    logic [19:0] cfg_data = '0;

    echo_scoreboard sb;
    bit             calm = 1'b0;     // no idling on either side while set
    int unsigned    ticks_sent = 0;

    ultrasonic_echo_ranger dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #30_000_000;
        $display("status: fail");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !out_stall)
            sb.check_reading(o_out_data);
    end

    // result side: random stall before each item
    initial begin
        int n;
        forever begin
            n = calm ? 0 : $urandom_range(0, 14);
            if (n != 0) begin
                out_stall = 1'b1;
                repeat (n) @(negedge i_clk);
                out_stall = 1'b0;
            end
            do @(posedge i_clk); while (!(i_rst_n && o_out_valid === 1'b1 && !out_stall));
            @(negedge i_clk);
        end
    end

    // called at a falling edge, returns at a falling edge with valid still high
    task automatic send_tick(bit cmd, bit echo);
        t_in it;
        int  gap;
        it.cmd        = cmd;
        it.echo_level = echo;
        gap = calm ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_data  = it;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_tick(it);
        ticks_sent++;
        @(negedge i_clk);
    endtask

    // start, trigger pulse, rise wait, echo high, one low tick
    task automatic run_ranging(int rise, int high, bit busy);
        int k;
        send_tick(1'b1, 1'($urandom_range(0, 1)));
        for (k = 1; k < 2 * TRIG_US; k++)
            send_tick(busy & 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        repeat (rise) send_tick(1'b0, 1'b0);
        repeat (high) send_tick(1'b0, 1'b1);
        send_tick(busy, 1'b0);
    endtask

    task automatic drain_readings();
        in_valid = 1'b0;
        while (sb.expected_readings.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [19:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        sb.set_reg(idx, val);
        @(negedge i_clk);
    endtask

    task automatic configure(logic [15:0] tmo, logic [17:0] thr, logic [19:0] hold);
        write_reg(CFG_TIMEOUT, {4'd0, tmo});
        write_reg(CFG_WARN_THR, {2'd0, thr});
        write_reg(CFG_WARN_HOLD, hold);
        cfg_valid = 1'b0;
    endtask

    initial begin
        int unsigned quota;
        int          p;
        int          tmo;
        sb = new();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed, reset settings
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        run_ranging(0, 1, 1'b1);
        run_ranging(3, 200, 1'b0);
        drain_readings();

        // short timeout, always close, one-tick hold
        configure(16'd5, 18'h3FFFF, 20'd1);
        run_ranging(2, 3, 1'b0);
        run_ranging(9, 1, 1'b0);
        run_ranging(0, 9, 1'b1);
        drain_readings();

        // zero timeout, zero threshold and hold
        configure(16'd0, 18'd0, 20'd0);
        run_ranging(1, 1, 1'b0);
        run_ranging(0, 3, 1'b0);
        drain_readings();

        configure(16'd1, DIST_MAX, 20'd2);
        run_ranging(0, 1, 1'b0);
        repeat (4) send_tick(1'b0, 1'b0);
        drain_readings();

        for (p = 0; p < 6; p++) begin
            tmo = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 70);
            configure(tmo[15:0],
                      (p == 1) ? 18'd0 : (p == 2) ? 18'h3FFFF : 18'($urandom_range(0, 300)),
                      (p == 3) ? 20'd0 : 20'($urandom_range(1, 400)));
            calm  = (p == 4);
            quota = ticks_sent + 180;
            while (ticks_sent < quota) begin
                if ($urandom_range(0, 5) == 0)
                    repeat ($urandom_range(1, 8))
                        send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                else
                    run_ranging($urandom_range(0, tmo + 2), $urandom_range(1, 70),
                                $urandom_range(0, 3) == 0);
            end
            drain_readings();
        end
        calm = 1'b0;

        if (sb.errors == 0 && sb.expected_readings.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

/* files.f */
+incdir+rtl/core
rtl/core/uer_pkg.sv
rtl/core/ultrasonic_echo_ranger.sv
test/testbench.sv
